// ===== hdl/bmw_pkg.sv =====
// shared types, request and status codes, and the hex font table for the byte memory
// no dependencies
package bmw_pkg;

    localparam int MEM_BYTES_DEF = 4096;
    localparam int FONT_BYTES = 80;
    localparam int FONT_IW = 7;
    localparam int BASE_W = 12;
    localparam logic [BASE_W-1:0] FONT_BASE_RESET = 12'd80;

    localparam logic [2:0] KIND_RD_BYTE = 3'd0;
    localparam logic [2:0] KIND_WR_BYTE = 3'd1;
    localparam logic [2:0] KIND_RD_WORD = 3'd2;
    localparam logic [2:0] KIND_WR_WORD = 3'd3;
    localparam logic [2:0] KIND_CLEAR   = 3'd4;
    localparam logic [2:0] KIND_FONT    = 3'd5;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_RANGE1 = 2'd1;
    localparam logic [1:0] ST_RANGE2 = 2'd2;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] address;
        logic [15:0] data;
    } bmw_in_t;

    typedef struct packed {
        logic [15:0] read_data;
        logic [1:0]  status;
    } bmw_out_t;

    localparam logic [7:0] FONT_ROM [FONT_BYTES] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0,
        8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0,
        8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10,
        8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0,
        8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90,
        8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0,
        8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

endpackage

// ===== hdl/bmw_ram.sv =====
// byte-wide synchronous ram, one write port and one registered read port
// no dependencies
module bmw_ram #(
    parameter int DEPTH = 4096,
    parameter int AW = 12
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [7:0]    wdata,
    input  logic [AW-1:0] raddr,
    output logic [7:0]    rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/byte_memory_with_word_access_core.sv =====
// top level of the byte memory: request sequencer, clear and font walks, output register
// depends on bmw_pkg and bmw_ram
//
//   channel  ports                 carries
//   input    s_valid s_ready       s_item  (kind, address, data)
//   result   m_valid m_ready       m_item  (read_data, status)
//   config   cfg_we                cfg_data (font_base)
//
// byte write 1 cycle, byte read 2, word write 2, word read 3 (one ram port each way)
// faulting and unused kinds 1 cycle; clear MEM_BYTES + 1 cycles, font load up to 81
// after reset a clearing pass of MEM_BYTES cycles runs with s_ready low
// a result waits in the output register; the sequencer holds it while m_ready is low
module byte_memory_with_word_access_core #(
    parameter int MEM_BYTES = bmw_pkg::MEM_BYTES_DEF
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  bmw_pkg::bmw_in_t         s_item,
    output logic                     m_valid,
    input  logic                     m_ready,
    output bmw_pkg::bmw_out_t        m_item,
    input  logic                     cfg_we,
    input  logic [bmw_pkg::BASE_W-1:0] cfg_data
);

    import bmw_pkg::*;

    localparam int AW = $clog2(MEM_BYTES);
    localparam logic [16:0] MEM_LIMIT = 17'(MEM_BYTES);
    localparam logic [AW-1:0] LAST_IDX = AW'(MEM_BYTES - 1);
    localparam logic [FONT_IW-1:0] FONT_LAST = FONT_IW'(FONT_BYTES - 1);

    typedef enum logic [6:0] {
        S_INIT  = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_RD1   = 7'b0000100,
        S_RD2   = 7'b0001000,
        S_WR2   = 7'b0010000,
        S_WALK  = 7'b0100000,
        S_WAIT  = 7'b1000000
    } state_t;

    state_t            state_reg, state_next;
    logic [AW-1:0]     walk_reg, walk_next;
    logic              font_reg, font_next;
    logic              word_reg, word_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic [7:0]        lo_reg, lo_next;
    logic [7:0]        hi_reg, hi_next;
    logic [BASE_W-1:0] font_base_reg;
    logic              m_valid_reg;
    bmw_out_t          out_reg, hold_reg;

    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [7:0]    mem_wdata, mem_rdata;

    logic          emit;
    bmw_out_t      res;
    logic          slot_free;
    logic          addr_ok, next_ok, font_ok;
    logic [16:0]   next_addr, font_addr;

    bmw_ram #(
        .DEPTH (MEM_BYTES),
        .AW    (AW)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign slot_free = !m_valid_reg || m_ready;
    assign next_addr = {1'b0, s_item.address} + 17'd1;
    assign addr_ok   = {1'b0, s_item.address} < MEM_LIMIT;
    assign next_ok   = next_addr < MEM_LIMIT;
    assign font_addr = 17'(font_base_reg) + 17'(walk_reg[FONT_IW-1:0]);
    assign font_ok   = font_addr < MEM_LIMIT;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_item  = out_reg;

    always_comb begin
        state_next = state_reg;
        walk_next  = walk_reg;
        font_next  = font_reg;
        word_next  = word_reg;
        idx_next   = idx_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_wdata  = '0;
        mem_raddr  = '0;
        emit       = 1'b0;
        res        = '{read_data: 16'd0, status: ST_OK};
        unique case (state_reg)
            S_INIT: begin
                mem_we    = 1'b1;
                mem_waddr = walk_reg;
                walk_next = walk_reg + 1'b1;
                if (walk_reg == LAST_IDX) begin
                    walk_next  = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    mem_raddr = s_item.address[AW-1:0];
                    idx_next  = next_addr[AW-1:0];
                    lo_next   = s_item.data[7:0];
                    case (s_item.kind)
                        KIND_RD_BYTE: begin
                            if (addr_ok) begin
                                word_next  = 1'b0;
                                state_next = S_RD1;
                            end else begin
                                emit       = 1'b1;
                                res.status = ST_RANGE1;
                            end
                        end
                        KIND_WR_BYTE: begin
                            emit = 1'b1;
                            if (addr_ok) begin
                                mem_we    = 1'b1;
                                mem_waddr = s_item.address[AW-1:0];
                                mem_wdata = s_item.data[7:0];
                            end else begin
                                res.status = ST_RANGE1;
                            end
                        end
                        KIND_RD_WORD: begin
                            if (!addr_ok) begin
                                emit       = 1'b1;
                                res.status = ST_RANGE1;
                            end else if (!next_ok) begin
                                emit       = 1'b1;
                                res.status = ST_RANGE2;
                            end else begin
                                word_next  = 1'b1;
                                state_next = S_RD1;
                            end
                        end
                        KIND_WR_WORD: begin
                            if (!addr_ok) begin
                                emit       = 1'b1;
                                res.status = ST_RANGE1;
                            end else begin
                                mem_we    = 1'b1;
                                mem_waddr = s_item.address[AW-1:0];
                                mem_wdata = s_item.data[15:8];
                                if (next_ok) begin
                                    state_next = S_WR2;
                                end else begin
                                    emit       = 1'b1;
                                    res.status = ST_RANGE2;
                                end
                            end
                        end
                        KIND_CLEAR: begin
                            walk_next  = '0;
                            font_next  = 1'b0;
                            state_next = S_WALK;
                        end
                        KIND_FONT: begin
                            walk_next  = '0;
                            font_next  = 1'b1;
                            state_next = S_WALK;
                        end
                        default: begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            S_RD1: begin
                if (word_reg) begin
                    hi_next    = mem_rdata;
                    mem_raddr  = idx_reg;
                    state_next = S_RD2;
                end else begin
                    emit          = 1'b1;
                    res.read_data = {8'd0, mem_rdata};
                end
            end
            S_RD2: begin
                emit          = 1'b1;
                res.read_data = {hi_reg, mem_rdata};
            end
            S_WR2: begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
                mem_wdata = lo_reg;
                emit      = 1'b1;
            end
            S_WALK: begin
                walk_next = walk_reg + 1'b1;
                if (font_reg) begin
                    if (!font_ok) begin
                        emit       = 1'b1;
                        res.status = ST_RANGE1;
                    end else begin
                        mem_we    = 1'b1;
                        mem_waddr = font_addr[AW-1:0];
                        mem_wdata = FONT_ROM[walk_reg[FONT_IW-1:0]];
                        if (walk_reg[FONT_IW-1:0] == FONT_LAST) begin
                            emit = 1'b1;
                        end
                    end
                end else begin
                    mem_we    = 1'b1;
                    mem_waddr = walk_reg;
                    if (walk_reg == LAST_IDX) begin
                        emit = 1'b1;
                    end
                end
            end
            S_WAIT: begin
                if (slot_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
        if (emit) begin
            state_next = slot_free ? S_IDLE : S_WAIT;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_INIT;
            walk_reg      <= '0;
            font_reg      <= 1'b0;
            word_reg      <= 1'b0;
            font_base_reg <= FONT_BASE_RESET;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            walk_reg  <= walk_next;
            font_reg  <= font_next;
            word_reg  <= word_next;
            if (cfg_we) begin
                font_base_reg <= cfg_data;
            end
            if ((emit || state_reg == S_WAIT) && slot_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        if (emit) begin
            hold_reg <= res;
        end
        if (emit && slot_free) begin
            out_reg <= res;
        end else if (state_reg == S_WAIT && slot_free) begin
            out_reg <= hold_reg;
        end
    end

endmodule
